[hdl/cps_pkg.sv]
// Shared types and constants for the cue playhead sequencer.
// Holds voice status codes, event codes, register indexes and the config bundle.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package cps_pkg;

	// Default parameter values for the top level
	localparam int ADDR_BITS_DEF  = 32;
	localparam int FADE_BITS_DEF  = 24;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field widths
	localparam int FUNC_W     = 3;
	localparam int FADE_LEN_W = 24;
	localparam int WORD_W     = 32;
	localparam int LOOP_W     = 16;
	localparam int FLAG_W     = 3;
	localparam int REG_IDX_W  = 3;

	// Voice status
	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_PRE  = 3'd1,
		ST_PLAY = 3'd2,
		ST_STOP = 3'd3,
		ST_FIN  = 3'd4
	} voice_mode_t;

	// Event codes
	localparam logic [FUNC_W-1:0] FN_TICK     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_START    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_STOP     = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RELEASE  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SCHEDULE = 3'd4;
	localparam logic [FUNC_W-1:0] FN_PAUSE    = 3'd5;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_REGION_START = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_REGION_END   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VAMP_START   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_VAMP_END     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PRE_WAIT     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LOOP_COUNT   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MODE_FLAGS   = 3'd6;

	// Mode flag bits
	localparam int FLAG_VAMP_EN   = 0;
	localparam int FLAG_REL_NOW   = 1;
	localparam int FLAG_LIVE      = 2;

	localparam logic [LOOP_W-1:0] LOOP_COUNT_RST = 16'd1;

	// Configuration bundle
	typedef struct packed {
		logic [WORD_W-1:0] region_start;
		logic [WORD_W-1:0] region_end;
		logic [WORD_W-1:0] vamp_start;
		logic [WORD_W-1:0] vamp_end;
		logic [WORD_W-1:0] pre_wait;
		logic [LOOP_W-1:0] loop_count;
		logic [FLAG_W-1:0] mode_flags;
	} cps_cfg_t;

endpackage

`default_nettype wire

[hdl/cps_cfg_regs.sv]
// Configuration register file of the cue playhead sequencer.
// Depends on cps_pkg for register indexes and the config bundle type.
`default_nettype none

module cps_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [cps_pkg::REG_IDX_W-1:0]    wr_index,
	input  wire logic [cps_pkg::WORD_W-1:0]       wr_data,
	output cps_pkg::cps_cfg_t                     cfg
);

	cps_pkg::cps_cfg_t cfg_q;

	// Write one register per handshake; drop indexes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_start <= '0;
			cfg_q.region_end   <= '0;
			cfg_q.vamp_start   <= '0;
			cfg_q.vamp_end     <= '0;
			cfg_q.pre_wait     <= '0;
			cfg_q.loop_count   <= cps_pkg::LOOP_COUNT_RST;
			cfg_q.mode_flags   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				cps_pkg::REG_REGION_START: cfg_q.region_start <= wr_data;
				cps_pkg::REG_REGION_END:   cfg_q.region_end   <= wr_data;
				cps_pkg::REG_VAMP_START:   cfg_q.vamp_start   <= wr_data;
				cps_pkg::REG_VAMP_END:     cfg_q.vamp_end     <= wr_data;
				cps_pkg::REG_PRE_WAIT:     cfg_q.pre_wait     <= wr_data;
				cps_pkg::REG_LOOP_COUNT:
					cfg_q.loop_count <= wr_data[cps_pkg::LOOP_W-1:0];
				cps_pkg::REG_MODE_FLAGS:
					cfg_q.mode_flags <= wr_data[cps_pkg::FLAG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hdl/cps_voice.sv]
// Voice state and per-item event update of the cue playhead sequencer.
// Depends on cps_pkg; the result of each item is driven combinationally.
`default_nettype none

module cps_voice #(
	parameter int ADDR_BITS  = cps_pkg::ADDR_BITS_DEF,
	parameter int FADE_BITS  = cps_pkg::FADE_BITS_DEF,
	parameter int COUNT_BITS = cps_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire cps_pkg::cps_cfg_t                 cfg,
	input  wire logic                              step,
	input  wire logic [cps_pkg::FUNC_W-1:0]        func,
	input  wire logic [cps_pkg::FADE_LEN_W-1:0]    fade_length,
	input  wire logic [cps_pkg::WORD_W-1:0]        stop_at,
	input  wire logic                              pause_flag,
	output logic                                   res_sounding,
	output logic [ADDR_BITS-1:0]                   res_address,
	output logic [2:0]                             res_status,
	output logic [COUNT_BITS-1:0]                  res_region_passes,
	output logic [COUNT_BITS-1:0]                  res_vamp_passes,
	output logic                                   res_vamp_looping,
	output logic [FADE_BITS-1:0]                   res_fade_elapsed,
	output logic [cps_pkg::WORD_W-1:0]             res_pass_samples,
	output logic [cps_pkg::WORD_W-1:0]             res_total_sounded
);

	localparam int CW  = (ADDR_BITS > cps_pkg::WORD_W) ? ADDR_BITS : cps_pkg::WORD_W;
	localparam int LCW = (COUNT_BITS > cps_pkg::LOOP_W) ? COUNT_BITS : cps_pkg::LOOP_W;

	// State registers
	cps_pkg::voice_mode_t          mode_q, mode_d;
	logic [ADDR_BITS-1:0]          pos_q, pos_d;
	logic [cps_pkg::WORD_W-1:0]    wait_q, wait_d;
	logic [cps_pkg::WORD_W-1:0]    psc_q, psc_d;
	logic [cps_pkg::WORD_W-1:0]    snd_q, snd_d;
	logic [COUNT_BITS-1:0]         rpc_q, rpc_d;
	logic [COUNT_BITS-1:0]         vpc_q, vpc_d;
	logic [cps_pkg::WORD_W-1:0]    target_q, target_d;
	logic                          stop_armed_q, stop_armed_d;
	logic [FADE_BITS-1:0]          armed_fade_q, armed_fade_d;
	logic [FADE_BITS-1:0]          fade_done_q, fade_done_d;
	logic [FADE_BITS-1:0]          fade_total_q, fade_total_d;
	logic                          end_on_fade_q, end_on_fade_d;
	logic                          vamp_armed_q, vamp_armed_d;
	logic                          release_seen_q, release_seen_d;
	logic                          frozen_q, frozen_d;
	logic                          release_pending_q, release_pending_d;

	// Config-derived terms
	logic [ADDR_BITS-1:0] rs_a, vs_a;
	logic                 pos_ge_ve, pos_ge_re, vs_ge_ve, vs_ge_re;
	logic                 fits, region_empty, more;
	logic                 live, vamp_en, rel_now;
	logic                 act;

	// Tick decision chain
	logic                  t_rel_seen, t_va0, vedge, vwrap, p1_ge_re, redge, rfin;
	logic [ADDR_BITS-1:0]  pos1, pos2;
	logic                  va1, va2;
	logic [COUNT_BITS-1:0] rpc_inc, vpc_inc, vpc1, vpc2, rpc2;
	logic [cps_pkg::WORD_W-1:0] psc2;
	logic                  sedge, sfin, eof3, efin;
	logic [FADE_BITS-1:0]  ft3, fd3, fd_n;

	logic                  snd_flag;
	logic [ADDR_BITS-1:0]  addr_d;

	assign live    = cfg.mode_flags[cps_pkg::FLAG_LIVE];
	assign vamp_en = cfg.mode_flags[cps_pkg::FLAG_VAMP_EN];
	assign rel_now = cfg.mode_flags[cps_pkg::FLAG_REL_NOW];

	assign rs_a = ADDR_BITS'(cfg.region_start);
	assign vs_a = ADDR_BITS'(cfg.vamp_start);

	// Compare position and vamp restart point against the markers
	assign pos_ge_ve = CW'(pos_q) >= CW'(cfg.vamp_end);
	assign pos_ge_re = CW'(pos_q) >= CW'(cfg.region_end);
	assign vs_ge_ve  = CW'(vs_a) >= CW'(cfg.vamp_end);
	assign vs_ge_re  = CW'(vs_a) >= CW'(cfg.region_end);

	assign fits = (cfg.vamp_end > cfg.vamp_start) && (cfg.vamp_start >= cfg.region_start)
		&& (cfg.vamp_end <= cfg.region_end);
	assign region_empty = cfg.region_end <= cfg.region_start;

	assign act = mode_q inside {cps_pkg::ST_PRE, cps_pkg::ST_PLAY, cps_pkg::ST_STOP};

	// Saturating pass counters
	assign rpc_inc = (rpc_q == '1) ? rpc_q : rpc_q + 1'b1;
	assign vpc_inc = (vpc_q == '1) ? vpc_q : vpc_q + 1'b1;
	assign more    = (cfg.loop_count == '0) || (LCW'(rpc_inc) < LCW'(cfg.loop_count));

	// Apply a latched release, then take vamp, region and stop decisions in order
	always_comb begin
		t_rel_seen = release_seen_q | release_pending_q;
		t_va0      = vamp_armed_q & ~(release_pending_q & rel_now);

		vedge    = t_va0 & pos_ge_ve;
		vwrap    = vedge & ~t_rel_seen;
		pos1     = vwrap ? vs_a : pos_q;
		va1      = vedge ? (vwrap & ~vs_ge_ve) : t_va0;
		vpc1     = vedge ? vpc_inc : vpc_q;
		p1_ge_re = vwrap ? vs_ge_re : pos_ge_re;

		redge = ~live & p1_ge_re;
		rfin  = redge & (~more | region_empty);
		pos2  = redge ? rs_a : pos1;
		va2   = redge ? (vamp_en & ~t_rel_seen & fits) : va1;
		vpc2  = redge ? '0 : vpc1;
		rpc2  = redge ? rpc_inc : rpc_q;
		psc2  = redge ? '0 : psc_q;

		sedge = stop_armed_q & (snd_q >= target_q);
		sfin  = sedge & ((mode_q == cps_pkg::ST_PRE) || (armed_fade_q == '0));
		ft3   = sedge ? armed_fade_q : fade_total_q;
		fd3   = sedge ? '0 : fade_done_q;
		eof3  = sedge | end_on_fade_q;
		fd_n  = (fd3 < ft3) ? fd3 + 1'b1 : fd3;
		efin  = eof3 & (fd_n >= ft3);
	end

	// Next state for one item
	always_comb begin
		mode_d            = mode_q;
		pos_d             = pos_q;
		wait_d            = wait_q;
		psc_d             = psc_q;
		snd_d             = snd_q;
		rpc_d             = rpc_q;
		vpc_d             = vpc_q;
		target_d          = target_q;
		stop_armed_d      = stop_armed_q;
		armed_fade_d      = armed_fade_q;
		fade_done_d       = fade_done_q;
		fade_total_d      = fade_total_q;
		end_on_fade_d     = end_on_fade_q;
		vamp_armed_d      = vamp_armed_q;
		release_seen_d    = release_seen_q;
		frozen_d          = frozen_q;
		release_pending_d = release_pending_q;
		snd_flag          = 1'b0;
		addr_d            = pos_q;

		case (func)
			cps_pkg::FN_TICK: begin
				if (act && !frozen_q) begin
					release_pending_d = 1'b0;
					release_seen_d    = t_rel_seen;
					vamp_armed_d      = t_va0;
					if (wait_q != '0) begin
						// Count down the pre-wait silently
						wait_d = wait_q - 1'b1;
						if (wait_q == 32'd1 && mode_q == cps_pkg::ST_PRE) begin
							mode_d = cps_pkg::ST_PLAY;
						end
					end else if (rfin) begin
						// Last region pass or empty region: finish
						pos_d        = pos1;
						vpc_d        = vpc1;
						rpc_d        = rpc2;
						mode_d       = cps_pkg::ST_FIN;
						vamp_armed_d = 1'b0;
					end else begin
						pos_d        = pos2;
						psc_d        = psc2;
						vpc_d        = vpc2;
						rpc_d        = rpc2;
						vamp_armed_d = va2;
						if (sedge) begin
							stop_armed_d = 1'b0;
						end
						if (sfin) begin
							mode_d       = cps_pkg::ST_FIN;
							vamp_armed_d = 1'b0;
						end else begin
							if (sedge) begin
								fade_total_d   = armed_fade_q;
								end_on_fade_d  = 1'b1;
								release_seen_d = 1'b1;
								vamp_armed_d   = 1'b0;
								mode_d         = cps_pkg::ST_STOP;
							end
							// Sound one sample and advance
							snd_flag    = 1'b1;
							addr_d      = pos2;
							pos_d       = pos2 + 1'b1;
							psc_d       = (psc2 == '1) ? psc2 : psc2 + 1'b1;
							snd_d       = (snd_q == '1) ? snd_q : snd_q + 1'b1;
							fade_done_d = fd_n;
							if (efin) begin
								mode_d       = cps_pkg::ST_FIN;
								vamp_armed_d = 1'b0;
							end
						end
					end
				end
			end
			cps_pkg::FN_START: begin
				pos_d             = rs_a;
				addr_d            = rs_a;
				wait_d            = cfg.pre_wait;
				psc_d             = '0;
				snd_d             = '0;
				rpc_d             = '0;
				vpc_d             = '0;
				stop_armed_d      = 1'b0;
				target_d          = '0;
				armed_fade_d      = '0;
				frozen_d          = 1'b0;
				release_seen_d    = 1'b0;
				release_pending_d = 1'b0;
				vamp_armed_d      = vamp_en & ~live & fits;
				fade_done_d       = '0;
				fade_total_d      = '0;
				end_on_fade_d     = 1'b0;
				mode_d = (cfg.pre_wait != '0) ? cps_pkg::ST_PRE : cps_pkg::ST_PLAY;
			end
			cps_pkg::FN_STOP: begin
				if (act) begin
					if (mode_q == cps_pkg::ST_PRE || fade_length == '0) begin
						mode_d       = cps_pkg::ST_FIN;
						vamp_armed_d = 1'b0;
					end else begin
						fade_total_d   = FADE_BITS'(fade_length);
						fade_done_d    = '0;
						end_on_fade_d  = 1'b1;
						release_seen_d = 1'b1;
						vamp_armed_d   = 1'b0;
						mode_d         = cps_pkg::ST_STOP;
					end
				end
			end
			cps_pkg::FN_RELEASE: begin
				if (mode_q != cps_pkg::ST_IDLE) begin
					release_pending_d = 1'b1;
				end
			end
			cps_pkg::FN_SCHEDULE: begin
				target_d     = stop_at;
				armed_fade_d = FADE_BITS'(fade_length);
				stop_armed_d = 1'b1;
			end
			cps_pkg::FN_PAUSE: begin
				frozen_d = pause_flag;
			end
			default: ;
		endcase
	end

	// Hold state between items; update once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q            <= cps_pkg::ST_IDLE;
			pos_q             <= '0;
			wait_q            <= '0;
			psc_q             <= '0;
			snd_q             <= '0;
			rpc_q             <= '0;
			vpc_q             <= '0;
			target_q          <= '0;
			stop_armed_q      <= 1'b0;
			armed_fade_q      <= '0;
			fade_done_q       <= '0;
			fade_total_q      <= '0;
			end_on_fade_q     <= 1'b0;
			vamp_armed_q      <= 1'b0;
			release_seen_q    <= 1'b0;
			frozen_q          <= 1'b0;
			release_pending_q <= 1'b0;
		end else if (step) begin
			mode_q            <= mode_d;
			pos_q             <= pos_d;
			wait_q            <= wait_d;
			psc_q             <= psc_d;
			snd_q             <= snd_d;
			rpc_q             <= rpc_d;
			vpc_q             <= vpc_d;
			target_q          <= target_d;
			stop_armed_q      <= stop_armed_d;
			armed_fade_q      <= armed_fade_d;
			fade_done_q       <= fade_done_d;
			fade_total_q      <= fade_total_d;
			end_on_fade_q     <= end_on_fade_d;
			vamp_armed_q      <= vamp_armed_d;
			release_seen_q    <= release_seen_d;
			frozen_q          <= frozen_d;
			release_pending_q <= release_pending_d;
		end
	end

	// Report the state after the item
	assign res_sounding      = snd_flag;
	assign res_address       = addr_d;
	assign res_status        = mode_d;
	assign res_region_passes = rpc_d;
	assign res_vamp_passes   = vpc_d;
	assign res_vamp_looping  = vamp_armed_d;
	assign res_fade_elapsed  = fade_done_d;
	assign res_pass_samples  = psc_d;
	assign res_total_sounded = snd_d;

endmodule

`default_nettype wire

[hdl/cue_playhead_sequencer.sv]
// An accepted item passes through the input register, then the result register, before
// its result is on the ports. Throughput: one item per cycle; a stalled full result
// register holds the input register, which then stalls the next item. Reset: arst_n
// clears the voice to idle, all counters to zero, loop_count to one and the other voice,
// config and valid registers, asynchronously; payload and result data are not reset.
// Top level; depends on cps_pkg, cps_cfg_regs and cps_voice.
`default_nettype none

module cue_playhead_sequencer #(
	parameter int ADDR_BITS  = cps_pkg::ADDR_BITS_DEF,
	parameter int FADE_BITS  = cps_pkg::FADE_BITS_DEF,
	parameter int COUNT_BITS = cps_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cps_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [cps_pkg::WORD_W-1:0]        cfg_data,
	// Event items
	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  wire logic [cps_pkg::FUNC_W-1:0]        func,
	input  wire logic [cps_pkg::FADE_LEN_W-1:0]    fade_length,
	input  wire logic [cps_pkg::WORD_W-1:0]        stop_at,
	input  wire logic                              pause_flag,
	// Result items
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic                                   sounding,
	output logic [ADDR_BITS-1:0]                   sample_address,
	output logic [2:0]                             voice_status,
	output logic [COUNT_BITS-1:0]                  region_passes,
	output logic [COUNT_BITS-1:0]                  vamp_passes,
	output logic                                   vamp_looping,
	output logic [FADE_BITS-1:0]                   stop_fade_elapsed,
	output logic [cps_pkg::WORD_W-1:0]             pass_samples,
	output logic [cps_pkg::WORD_W-1:0]             total_sounded
);

	cps_pkg::cps_cfg_t cfg;

	// Input register
	logic                               valid_s1;
	logic [cps_pkg::FUNC_W-1:0]         func_s1;
	logic [cps_pkg::FADE_LEN_W-1:0]     fade_s1;
	logic [cps_pkg::WORD_W-1:0]         stop_at_s1;
	logic                               pause_s1;

	logic advance;
	logic item_take;

	// Combinational result of the item in the input register
	logic                          r_sounding;
	logic [ADDR_BITS-1:0]          r_address;
	logic [2:0]                    r_status;
	logic [COUNT_BITS-1:0]         r_region_passes;
	logic [COUNT_BITS-1:0]         r_vamp_passes;
	logic                          r_vamp_looping;
	logic [FADE_BITS-1:0]          r_fade_elapsed;
	logic [cps_pkg::WORD_W-1:0]    r_pass_samples;
	logic [cps_pkg::WORD_W-1:0]    r_total_sounded;

	// Result register
	logic                          result_valid_q;
	logic                          sounding_q;
	logic [ADDR_BITS-1:0]          address_q;
	logic [2:0]                    status_q;
	logic [COUNT_BITS-1:0]         region_passes_q;
	logic [COUNT_BITS-1:0]         vamp_passes_q;
	logic                          vamp_looping_q;
	logic [FADE_BITS-1:0]          fade_elapsed_q;
	logic [cps_pkg::WORD_W-1:0]    pass_samples_q;
	logic [cps_pkg::WORD_W-1:0]    total_sounded_q;

	assign cfg_ready = 1'b1;

	cps_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the held item forward when the result register is free or drains
	assign advance    = valid_s1 & (~result_valid_q | ~result_stall);
	assign item_stall = valid_s1 & ~advance;
	assign item_take  = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= item_take | (valid_s1 & ~advance);
		end
	end

	// Capture the item payload
	always_ff @(posedge clk) begin
		if (item_take) begin
			func_s1    <= func;
			fade_s1    <= fade_length;
			stop_at_s1 <= stop_at;
			pause_s1   <= pause_flag;
		end
	end

	cps_voice #(
		.ADDR_BITS  (ADDR_BITS),
		.FADE_BITS  (FADE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_voice (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.step              (advance),
		.func              (func_s1),
		.fade_length       (fade_s1),
		.stop_at           (stop_at_s1),
		.pause_flag        (pause_s1),
		.res_sounding      (r_sounding),
		.res_address       (r_address),
		.res_status        (r_status),
		.res_region_passes (r_region_passes),
		.res_vamp_passes   (r_vamp_passes),
		.res_vamp_looping  (r_vamp_looping),
		.res_fade_elapsed  (r_fade_elapsed),
		.res_pass_samples  (r_pass_samples),
		.res_total_sounded (r_total_sounded)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= advance | (result_valid_q & result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sounding_q      <= r_sounding;
			address_q       <= r_address;
			status_q        <= r_status;
			region_passes_q <= r_region_passes;
			vamp_passes_q   <= r_vamp_passes;
			vamp_looping_q  <= r_vamp_looping;
			fade_elapsed_q  <= r_fade_elapsed;
			pass_samples_q  <= r_pass_samples;
			total_sounded_q <= r_total_sounded;
		end
	end

	assign result_valid      = result_valid_q;
	assign sounding          = sounding_q;
	assign sample_address    = address_q;
	assign voice_status      = status_q;
	assign region_passes     = region_passes_q;
	assign vamp_passes       = vamp_passes_q;
	assign vamp_looping      = vamp_looping_q;
	assign stop_fade_elapsed = fade_elapsed_q;
	assign pass_samples      = pass_samples_q;
	assign total_sounded     = total_sounded_q;

endmodule

`default_nettype wire

[hdl/cps_checker.sv]
// Port-level checks for the cue playhead sequencer, bound to the top level.
// Depends on cps_pkg for the voice status codes.
`default_nettype none

module cps_checker #(
	parameter int FADE_BITS = cps_pkg::FADE_BITS_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 result_valid,
	input wire logic                 result_stall,
	input wire logic                 sounding,
	input wire logic [2:0]           voice_status,
	input wire logic                 vamp_looping,
	input wire logic [FADE_BITS-1:0] stop_fade_elapsed
);

	// Hold a stalled result
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	// Sound only while playing, stopping, or on the sample that ends the fade
	a_sound_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sounding |->
			voice_status == cps_pkg::ST_PLAY || voice_status == cps_pkg::ST_STOP ||
			voice_status == cps_pkg::ST_FIN)
		else $error("sample sounded in a silent status");

	// Keep the fade counter clear until a stop begins
	a_fade_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (voice_status == cps_pkg::ST_IDLE ||
			voice_status == cps_pkg::ST_PRE || voice_status == cps_pkg::ST_PLAY) |->
			stop_fade_elapsed == '0)
		else $error("stop fade counted outside a stop");

	// Arm the vamp only before the stop
	a_vamp_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && vamp_looping |->
			voice_status == cps_pkg::ST_PRE || voice_status == cps_pkg::ST_PLAY)
		else $error("vamp armed while stopping, finished or idle");

endmodule

bind cue_playhead_sequencer cps_checker #(
	.FADE_BITS (FADE_BITS)
) u_cps_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.sounding          (sounding),
	.voice_status      (voice_status),
	.vamp_looping      (vamp_looping),
	.stop_fade_elapsed (stop_fade_elapsed)
);

`default_nettype wire
